// ===== design/cma_pkg.sv =====
// shared types and constants for the centered moving average block
// no dependencies; used by the top, datapath and controller modules of the block

package cma_pkg;

    localparam int MAX_HALF_WIDTH_DEF = 15;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int CFG_BITS           = 5;
    localparam logic [CFG_BITS-1:0] WINDOW_WIDTH_RESET = 5'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_OLD,
        ST_UPDATE,
        ST_DECIDE,
        ST_DIVIDE,
        ST_EMIT_AVG,
        ST_EMIT_PASS,
        ST_FLUSH_READ,
        ST_EMIT_FLUSH
    } cma_state_t;

    typedef struct packed {
        logic accept;
        logic rd_old;
        logic update;
        logic decide;
        logic div_start;
        logic rd_back;
        logic rd_flush;
        logic load;
        logic load_avg;
        logic clear;
    } cma_cmd_t;

    typedef struct packed {
        logic gt_h;
        logic ge_win;
        logic m_zero;
        logic last;
        logic div_done;
        logic out_free;
    } cma_stat_t;

endpackage

// ===== design/centered_moving_average_top.sv =====
// Centered moving average over blocks of signed samples. Each output is the
// mean, truncated toward zero, of the 2h+1 original samples centred on it,
// h = (window_width-1)/2 capped at MAX_HALF_WIDTH; the first and last h
// samples of a block, and all samples of a block shorter than the window,
// pass through with was_averaged low. Output lags input by h samples and the
// last flag flushes the held tail, oldest first. One item is processed at a
// time. An averaged output waits for the bit-serial divider, which produces
// one quotient bit per cycle; flushed samples are read one after another
// through the single read port of the sample ring, and a stalled output
// holds the block until it is taken.
// A window_width write clears the partial block and must be made while idle.
// depends on cma_pkg, cma_ctrl and cma_datapath

module centered_moving_average_top #(
    parameter int MAX_HALF_WIDTH = cma_pkg::MAX_HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS    = cma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cma_pkg::CFG_BITS-1:0]  cfg_window_width,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                          s_last_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_was_averaged,
    output logic                          m_last_out
);

    cma_pkg::cma_cmd_t  cmd;
    cma_pkg::cma_stat_t stat;

    assign cfg_ready = 1'b1;

    cma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cma_datapath #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_window_width (cfg_window_width),
        .s_sample_in      (s_sample_in),
        .s_last_in        (s_last_in),
        .m_ready          (m_ready),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_sample_out     (m_sample_out),
        .m_was_averaged   (m_was_averaged),
        .m_last_out       (m_last_out)
    );

endmodule

// ===== design/cma_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies

module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 31
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/cma_div.sv =====
// bit-serial signed divider, one quotient bit per cycle, truncates toward zero
// no dependencies

module cma_div #(
    parameter int DIVIDEND_BITS = 21,
    parameter int DIVISOR_BITS  = 5,
    parameter int RESULT_BITS   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic signed [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]         divisor,
    output logic                            done,
    output logic signed [RESULT_BITS-1:0]   quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg, dsr_next;
    logic                     neg_reg, neg_next;
    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;
    logic [DIVIDEND_BITS-1:0] signed_quo;

    always_comb begin
        shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = shifted >= {1'b0, dsr_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DIVIDEND_BITS);
            rem_next  = '0;
            quo_next  = dividend[DIVIDEND_BITS-1] ? DIVIDEND_BITS'(-dividend)
                                                  : DIVIDEND_BITS'(dividend);
            dsr_next  = divisor;
            neg_next  = dividend[DIVIDEND_BITS-1];
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign signed_quo = neg_reg ? DIVIDEND_BITS'(-quo_reg) : quo_reg;
    assign quotient   = signed_quo[RESULT_BITS-1:0];
    assign done       = done_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) start |-> !busy_reg)
        else $error("divider started while busy");
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

// ===== design/cma_datapath.sv =====
// datapath: sample ring, running sum, block count, flush counter, output register
// depends on cma_pkg, cma_ram and cma_div

module cma_datapath #(
    parameter int MAX_HALF_WIDTH = cma_pkg::MAX_HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS    = cma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [cma_pkg::CFG_BITS-1:0]        cfg_window_width,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_in,
    input  logic                                s_last_in,
    input  logic                                m_ready,
    input  cma_pkg::cma_cmd_t                   cmd,
    output cma_pkg::cma_stat_t                  stat,
    output logic                                m_valid,
    output logic signed [SAMPLE_BITS-1:0]       m_sample_out,
    output logic                                m_was_averaged,
    output logic                                m_last_out
);

    localparam int RING_DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int ADDR_BITS  = $clog2(RING_DEPTH);
    localparam int IDX_BITS   = ADDR_BITS + 1;
    localparam int HALF_BITS  = $clog2(MAX_HALF_WIDTH + 1);
    localparam int COUNT_BITS = HALF_BITS + 1;
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(RING_DEPTH);

    logic [cma_pkg::CFG_BITS-1:0]  width_reg, width_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic [ADDR_BITS-1:0]          ws_reg, ws_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [HALF_BITS-1:0]          m_reg, m_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                          last_reg, last_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg, m_sample_next;
    logic                          m_avg_reg, m_avg_next;
    logic                          m_last_reg, m_last_next;

    logic [cma_pkg::CFG_BITS-1:0]  h_raw;
    logic [HALF_BITS-1:0]          h;
    logic [COUNT_BITS-1:0]         win;
    logic                          ge_win;
    logic                          out_free;
    logic [IDX_BITS-1:0]           offset;
    logic [IDX_BITS-1:0]           addr_sum;
    logic [ADDR_BITS-1:0]          raddr;
    logic                          re;
    logic signed [SAMPLE_BITS-1:0] rdata;
    logic signed [SUM_BITS-1:0]    x_ext;
    logic signed [SUM_BITS-1:0]    old_ext;
    logic                          div_done;
    logic signed [SAMPLE_BITS-1:0] div_q;

    // half width and window from the width register
    always_comb begin
        h_raw = (width_reg == '0) ? '0
              : (width_reg - cma_pkg::CFG_BITS'(1)) >> 1;
        h     = (int'(h_raw) > MAX_HALF_WIDTH) ? HALF_BITS'(MAX_HALF_WIDTH)
                                               : HALF_BITS'(h_raw);
        win   = {h, 1'b1};
        ge_win = count_reg >= win;
    end

    // ring read address: oldest sample, back(h) or back(m-1)
    always_comb begin
        if (cmd.rd_old) begin
            offset = IDX_BITS'(win);
        end else if (cmd.rd_back) begin
            offset = IDX_BITS'(h) + IDX_BITS'(1);
        end else begin
            offset = IDX_BITS'(m_reg);
        end
        addr_sum = IDX_BITS'(ws_reg) + IDX_BITS'(RING_DEPTH) - offset;
        raddr    = (addr_sum >= IDX_BITS'(RING_DEPTH))
                 ? ADDR_BITS'(addr_sum - IDX_BITS'(RING_DEPTH))
                 : ADDR_BITS'(addr_sum);
        re       = cmd.rd_old | cmd.rd_back | cmd.rd_flush;
    end

    assign x_ext   = {{(SUM_BITS - SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};
    assign old_ext = {{(SUM_BITS - SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata};
    assign out_free = !m_valid_reg || m_ready;

    cma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (ws_reg),
        .wdata (x_reg),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    cma_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (COUNT_BITS),
        .RESULT_BITS   (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (win),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        width_next = width_reg;
        count_next = count_reg;
        ws_next    = ws_reg;
        sum_next   = sum_reg;
        m_next     = m_reg;
        x_next     = x_reg;
        last_next  = last_reg;
        if (cmd.accept) begin
            x_next    = s_sample_in;
            last_next = s_last_in;
        end
        if (cmd.update) begin
            sum_next = sum_reg - (ge_win ? old_ext : '0) + x_ext;
            ws_next  = (ws_reg == ADDR_BITS'(RING_DEPTH - 1)) ? '0
                                                              : ws_reg + ADDR_BITS'(1);
            if (!ge_win) begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
        if (cmd.decide) begin
            m_next = (count_reg < COUNT_BITS'(h)) ? HALF_BITS'(count_reg) : h;
        end
        if (cmd.rd_flush) begin
            m_next = m_reg - HALF_BITS'(1);
        end
        if (cmd.clear || cfg_valid) begin
            count_next = '0;
            ws_next    = '0;
            sum_next   = '0;
        end
        if (cfg_valid) begin
            width_next = cfg_window_width;
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_sample_next = m_sample_reg;
        m_avg_next    = m_avg_reg;
        m_last_next   = m_last_reg;
        if (cmd.load) begin
            m_valid_next  = 1'b1;
            m_sample_next = cmd.load_avg ? div_q : rdata;
            m_avg_next    = cmd.load_avg;
            m_last_next   = last_reg && (m_reg == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= cma_pkg::WINDOW_WIDTH_RESET;
            count_reg   <= '0;
            ws_reg      <= '0;
            sum_reg     <= '0;
            m_reg       <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            count_reg   <= count_next;
            ws_reg      <= ws_next;
            sum_reg     <= sum_next;
            m_reg       <= m_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        m_sample_reg <= m_sample_next;
        m_avg_reg    <= m_avg_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        stat.gt_h     = count_reg > COUNT_BITS'(h);
        stat.ge_win   = ge_win;
        stat.m_zero   = m_reg == '0;
        stat.last     = last_reg;
        stat.div_done = div_done;
        stat.out_free = out_free;
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_out   = m_sample_reg;
    assign m_was_averaged = m_avg_reg;
    assign m_last_out     = m_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= win)
        else $error("block count beyond window");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("running sum nonzero on empty block");
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.load |-> out_free)
        else $error("output register overwritten");

endmodule

// ===== design/cma_ctrl.sv =====
// controller state machine sequencing ring access, divide, emit and flush
// depends on cma_pkg

module cma_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cma_pkg::cma_stat_t stat,
    output cma_pkg::cma_cmd_t  cmd
);

    cma_pkg::cma_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cma_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = cma_pkg::ST_READ_OLD;
                end
            end
            cma_pkg::ST_READ_OLD: begin
                state_next = cma_pkg::ST_UPDATE;
            end
            cma_pkg::ST_UPDATE: begin
                state_next = cma_pkg::ST_DECIDE;
            end
            cma_pkg::ST_DECIDE: begin
                if (stat.gt_h) begin
                    state_next = stat.ge_win ? cma_pkg::ST_DIVIDE : cma_pkg::ST_EMIT_PASS;
                end else if (stat.last) begin
                    state_next = cma_pkg::ST_FLUSH_READ;
                end else begin
                    state_next = cma_pkg::ST_IDLE;
                end
            end
            cma_pkg::ST_DIVIDE: begin
                if (stat.div_done) begin
                    state_next = cma_pkg::ST_EMIT_AVG;
                end
            end
            cma_pkg::ST_EMIT_AVG, cma_pkg::ST_EMIT_PASS: begin
                if (stat.out_free) begin
                    if (stat.last && !stat.m_zero) begin
                        state_next = cma_pkg::ST_FLUSH_READ;
                    end else begin
                        state_next = cma_pkg::ST_IDLE;
                    end
                end
            end
            cma_pkg::ST_FLUSH_READ: begin
                state_next = cma_pkg::ST_EMIT_FLUSH;
            end
            cma_pkg::ST_EMIT_FLUSH: begin
                if (stat.out_free) begin
                    state_next = stat.m_zero ? cma_pkg::ST_IDLE : cma_pkg::ST_FLUSH_READ;
                end
            end
            default: begin
                state_next = cma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            cma_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            cma_pkg::ST_READ_OLD: begin
                cmd.rd_old = 1'b1;
            end
            cma_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            cma_pkg::ST_DECIDE: begin
                cmd.decide    = 1'b1;
                cmd.div_start = stat.gt_h && stat.ge_win;
                cmd.rd_back   = stat.gt_h && !stat.ge_win;
            end
            cma_pkg::ST_DIVIDE: begin
                cmd = '0;
            end
            cma_pkg::ST_EMIT_AVG: begin
                cmd.load     = stat.out_free;
                cmd.load_avg = stat.out_free;
                cmd.clear    = stat.out_free && stat.last && stat.m_zero;
            end
            cma_pkg::ST_EMIT_PASS: begin
                cmd.load  = stat.out_free;
                cmd.clear = stat.out_free && stat.last && stat.m_zero;
            end
            cma_pkg::ST_FLUSH_READ: begin
                cmd.rd_flush = 1'b1;
            end
            cma_pkg::ST_EMIT_FLUSH: begin
                cmd.load  = stat.out_free;
                cmd.clear = stat.out_free && stat.m_zero;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cma_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== bench/centered_moving_average_top_tb.sv =====
// testbench for centered_moving_average_top: random valid/ready traffic, blocks of samples
// checked output by output against an in-bench window/sum predictor
// depends on cma_pkg and centered_moving_average_top

`timescale 1ns / 1ps

module centered_moving_average_top_tb;

    localparam int SAMPLE_BITS_DEF = cma_pkg::SAMPLE_BITS_DEF;
    localparam int CFG_BITS        = cma_pkg::CFG_BITS;
    localparam int HALF_CAP      = cma_pkg::MAX_HALF_WIDTH_DEF;
    localparam int RING_SLOTS    = 2 * HALF_CAP + 1;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 40;
    localparam int IDLE_PERCENT  = 21;
    localparam int PRINT_CAP     = 50;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] sample;
        logic                              last;
    } sample_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] sample;
        logic                              averaged;
        logic                              last;
    } filtered_sample_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_BITS-1:0] cfg_window_width = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_BITS_DEF-1:0] s_sample_in = '0;
    logic s_last_in = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SAMPLE_BITS_DEF-1:0] m_sample_out;
    logic m_was_averaged;
    logic m_last_out;

    sample_item_t     samples_to_send[$];
    filtered_sample_t expected_outputs[$];

    // predictor state
    logic signed [SAMPLE_BITS_DEF-1:0] ring[RING_SLOTS];
    longint window_sum = 0;
    int fill_count = 0;
    int write_pos = 0;
    logic [CFG_BITS-1:0] width_reg = cma_pkg::WINDOW_WIDTH_RESET;

    int items_queued = 0;
    int items_accepted = 0;
    int blocks_sent = 0;
    int results_seen = 0;
    int averaged_seen = 0;
    int widths_written = 0;
    int error_count = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    logic steady = 1'b0;

    centered_moving_average_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_window_width (cfg_window_width),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_in      (s_sample_in),
        .s_last_in        (s_last_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample_out     (m_sample_out),
        .m_was_averaged   (m_was_averaged),
        .m_last_out       (m_last_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        error_count++;
    endtask

    function automatic int half_of(input logic [CFG_BITS-1:0] w);
        int half;
        half = (w == 0) ? 0 : (int'(w) - 1) / 2;
        return (half > HALF_CAP) ? HALF_CAP : half;
    endfunction

    function automatic logic signed [SAMPLE_BITS_DEF-1:0] ring_back(input int b);
        return ring[(write_pos + RING_SLOTS - 1 - b) % RING_SLOTS];
    endfunction

    task automatic clear_block();
        window_sum = 0;
        fill_count = 0;
        write_pos = 0;
    endtask

    task automatic predict_sample(input logic signed [SAMPLE_BITS_DEF-1:0] x,
                                  input logic last_flag);
        int half;
        int win;
        int flush;
        filtered_sample_t r;
        half = half_of(width_reg);
        win = 2 * half + 1;
        if (fill_count >= win) begin
            window_sum -= longint'(ring[(write_pos + RING_SLOTS - win) % RING_SLOTS]);
        end
        ring[write_pos] = x;
        window_sum += longint'(x);
        write_pos = (write_pos + 1) % RING_SLOTS;
        if (fill_count < win) begin
            fill_count++;
        end
        flush = !last_flag ? 0 : (fill_count < half) ? fill_count : half;
        if (fill_count > half) begin
            if (fill_count >= win) begin
                r.sample = SAMPLE_BITS_DEF'(window_sum / longint'(win));
                r.averaged = 1'b1;
            end else begin
                r.sample = ring_back(half);
                r.averaged = 1'b0;
            end
            r.last = last_flag && (flush == 0);
            expected_outputs.push_back(r);
        end
        while (flush > 0) begin
            flush--;
            r.sample = ring_back(flush);
            r.averaged = 1'b0;
            r.last = (flush == 0);
            expected_outputs.push_back(r);
        end
        if (last_flag) begin
            clear_block();
        end
    endtask

    always @(posedge aclk) begin : drive_samples
        logic next_valid;
        sample_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                predict_sample(s_sample_in, s_last_in);
                items_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid && samples_to_send.size() > 0 &&
                (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                item = samples_to_send.pop_front();
                s_sample_in <= item.sample;
                s_last_in <= item.last;
                next_valid = 1'b1;
            end
            s_valid <= next_valid;
        end
    end

    always @(posedge aclk) begin : check_outputs
        filtered_sample_t want;
        logic next_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_was_averaged) begin
                    averaged_seen++;
                end
                if (expected_outputs.size() == 0) begin
                    report_mismatch($sformatf("unexpected output sample %0d", m_sample_out));
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_sample_out !== want.sample) begin
                        report_mismatch($sformatf("output %0d: sample_out %0d, want %0d",
                                                  results_seen, m_sample_out, want.sample));
                    end
                    if (m_was_averaged !== want.averaged) begin
                        report_mismatch($sformatf("output %0d: was_averaged %b, want %b",
                                                  results_seen, m_was_averaged,
                                                  want.averaged));
                    end
                    if (m_last_out !== want.last) begin
                        report_mismatch($sformatf("output %0d: last_out %b, want %b",
                                                  results_seen, m_last_out, want.last));
                    end
                end
            end
            // long back-pressure so the block stalls its input
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                next_ready = steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
            m_ready <= next_ready;
        end
    end

    task automatic push_sample(input logic signed [SAMPLE_BITS_DEF-1:0] v, input logic l);
        sample_item_t item;
        item.sample = v;
        item.last = l;
        samples_to_send.push_back(item);
        items_queued++;
        if (l) begin
            blocks_sent++;
        end
    endtask

    task automatic wait_idle();
        while (items_accepted != items_queued || expected_outputs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_width(input logic [CFG_BITS-1:0] w);
        wait_idle();
        cfg_window_width <= w;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        width_reg = w;
        clear_block();
        widths_written++;
    endtask

    function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample();
        logic signed [SAMPLE_BITS_DEF-1:0] v;
        case ($urandom_range(9))
            0: v = 16'sh8000;
            1: v = 16'sh7fff;
            2: v = '0;
            3: v = -16'sd1;
            4, 5: v = SAMPLE_BITS_DEF'($urandom_range(200)) - 16'sd100;
            default: v = SAMPLE_BITS_DEF'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_random_phase(input logic [CFG_BITS-1:0] w, input int budget);
        int win;
        int len;
        int sent;
        write_width(w);
        win = 2 * half_of(w) + 1;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(1, 2 * win + 4);
            end else begin
                len = $urandom_range(1, win + 6);
            end
            for (int i = 0; i < len; i++) begin
                push_sample(pick_sample(), i == len - 1);
            end
            sent += len;
        end
        // unterminated tail, dropped by the next width write
        if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(1, 4)) push_sample(pick_sample(), 1'b0);
        end
    endtask

    initial begin : run_phases
        logic [CFG_BITS-1:0] random_widths[6];
        for (int i = 0; i < RING_SLOTS; i++) begin
            ring[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset width: extremes averaged, then short blocks
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh8000, 1'b1);
        push_sample(16'sd1234, 1'b1);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd0, 1'b1);
        // partial block cut off by a width write
        push_sample(16'sd100, 1'b0);
        push_sample(16'sd200, 1'b0);
        write_width(5'd0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sd5, 1'b1);
        write_width(5'd31);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b1);
        // even width, which gives a one-sample window, with negative samples
        write_width(5'd2);
        push_sample(-16'sd1, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(-16'sd1, 1'b1);

        random_widths = '{5'd30, 5'd1, 5'd5, CFG_BITS'($urandom), 5'd31, 5'd4};
        for (int p = 0; p < 6; p++) begin
            send_random_phase(random_widths[p], 24);
            steady = (p == 2);
        end
        steady = 1'b0;

        wait_idle();
        if (expected_outputs.size() != 0) begin
            report_mismatch($sformatf("%0d expected outputs never arrived",
                                      expected_outputs.size()));
        end
        $display("covered %0d samples in %0d blocks over %0d window widths",
                 items_accepted, blocks_sent, widths_written + 1);
        $display("checked %0d outputs, %0d of them window means", results_seen,
                 averaged_seen);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout: %0d samples accepted, %0d outputs still expected",
                 items_accepted, expected_outputs.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
